>>> rtl/core/att_pkg.sv
// att_pkg: shared widths, event codes and defaults for the allocation tracking table.
// No dependencies; used by the interfaces, the RAM users and the top level.
package att_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int FUNC_W            = 2;
    localparam int ADDR_W            = 64;
    localparam int SIZE_W            = 32;
    localparam int LIVE_W            = 11;
    localparam int TOTAL_W           = 42;
    localparam int ENTRY_W           = ADDR_W + SIZE_W;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESIZE  = 2'd2;

endpackage

>>> rtl/core/att_if.sv
// att_if: valid/ready channel interfaces for event words and result words.
// Depends on att_pkg for field widths.
interface att_event_if;
    logic                          valid;
    logic                          ready;
    logic [att_pkg::FUNC_W-1:0]    func;
    logic [att_pkg::ADDR_W-1:0]    new_address;
    logic [att_pkg::ADDR_W-1:0]    old_address;
    logic [att_pkg::SIZE_W-1:0]    byte_count;

    modport source (output valid, func, new_address, old_address, byte_count, input ready);
    modport sink   (input valid, func, new_address, old_address, byte_count, output ready);
endinterface

interface att_result_if;
    logic                          valid;
    logic                          ready;
    logic                          recorded;
    logic                          released;
    logic [att_pkg::LIVE_W-1:0]    live_count;
    logic [att_pkg::TOTAL_W-1:0]   total_bytes;
    logic [att_pkg::TOTAL_W-1:0]   peak_bytes;

    modport source (output valid, recorded, released, live_count, total_bytes, peak_bytes,
                    input ready);
    modport sink   (input valid, recorded, released, live_count, total_bytes, peak_bytes,
                    output ready);
endinterface

>>> rtl/core/att_ram.sv
// att_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module att_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/allocation_tracking_table.sv
// allocation_tracking_table: live allocation table with running and peak byte totals.
// Depends on att_pkg, att_if (att_event_if, att_result_if) and att_ram.
//
// Usage: events arrive on i_event (valid/ready); one result word per event leaves
// on o_result (valid/ready). The block handles one event at a time and drops ready
// from acceptance until its result is loaded into the output register.
// Steps per event: record, then update the peak, then for a release or resize a
// scan of the table RAM at one entry per cycle, on a hit followed by moving the last
// entry into the freed slot, then post the result. The scan reads the entries
// below the count through the single read port of the entry RAM.
// Reset (synchronous, i_rst_n low) empties the table and clears both totals; the
// RAM contents are not cleared, entries at or above the count are never used.
// When the receiver stalls, the finished result waits in the output register and
// the next event is still taken and processed; it waits before posting its own
// result until the register frees up.
module allocation_tracking_table #(
    parameter int TABLE_ENTRIES = att_pkg::TABLE_ENTRIES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    att_event_if.sink    i_event,
    att_result_if.source o_result
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE, S_REC, S_PEAK, S_SCAN, S_LAST_RD, S_LAST_WR, S_DONE
    } t_state;

    t_state                        r_state;
    logic [att_pkg::FUNC_W-1:0]    r_func;
    logic [att_pkg::ADDR_W-1:0]    r_new_addr;
    logic [att_pkg::ADDR_W-1:0]    r_old_addr;
    logic [att_pkg::SIZE_W-1:0]    r_bytes;
    logic [CW-1:0]                 r_count;
    logic [att_pkg::TOTAL_W-1:0]   r_total;
    logic [att_pkg::TOTAL_W-1:0]   r_peak;
    logic                          r_rec;
    logic                          r_rel;
    logic [CW-1:0]                 r_rd_idx;
    logic [CW-1:0]                 r_cmp_idx;
    logic                          r_cmp_vld;
    logic [AW-1:0]                 r_hit_idx;
    logic [att_pkg::SIZE_W-1:0]    r_hit_size;

    logic                          r_out_vld;
    logic                          r_out_rec;
    logic                          r_out_rel;
    logic [att_pkg::LIVE_W-1:0]    r_out_live;
    logic [att_pkg::TOTAL_W-1:0]   r_out_total;
    logic [att_pkg::TOTAL_W-1:0]   r_out_peak;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [att_pkg::ENTRY_W-1:0]   ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [att_pkg::ENTRY_W-1:0]   ram_rdata;

    logic                          do_rec;
    logic                          want_rel;
    logic                          hit;
    logic                          out_load;
    logic [CW-1:0]                 count_m1;

    assign count_m1 = r_count - CW'(1);
    assign do_rec   = ((r_func == att_pkg::FUNC_ALLOC) || (r_func == att_pkg::FUNC_RESIZE))
                      && (r_new_addr != '0) && (r_count < FULL_COUNT);
    assign want_rel = ((r_func == att_pkg::FUNC_RELEASE) || (r_func == att_pkg::FUNC_RESIZE))
                      && (r_old_addr != '0) && (r_count != '0);
    assign hit      = r_cmp_vld
                      && (ram_rdata[att_pkg::ENTRY_W-1:att_pkg::SIZE_W] == r_old_addr);
    assign out_load = (r_state == S_DONE) && (!r_out_vld || o_result.ready);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = {r_new_addr, r_bytes};
        ram_raddr = r_rd_idx[AW-1:0];
        case (r_state)
            S_REC: begin
                ram_we = do_rec;
            end
            S_LAST_RD: begin
                ram_raddr = count_m1[AW-1:0];
            end
            S_LAST_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_hit_idx;
                ram_wdata = ram_rdata;
            end
            default: begin
            end
        endcase
    end

    att_ram #(
        .WIDTH (att_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_event.ready        = (r_state == S_IDLE);
    assign o_result.valid       = r_out_vld;
    assign o_result.recorded    = r_out_rec;
    assign o_result.released    = r_out_rel;
    assign o_result.live_count  = r_out_live;
    assign o_result.total_bytes = r_out_total;
    assign o_result.peak_bytes  = r_out_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_total   <= '0;
            r_peak    <= '0;
            r_out_vld <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld   <= 1'b1;
                r_out_rec   <= r_rec;
                r_out_rel   <= r_rel;
                r_out_live  <= att_pkg::LIVE_W'(r_count);
                r_out_total <= r_total;
                r_out_peak  <= r_peak;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_event.valid) begin
                        r_func     <= i_event.func;
                        r_new_addr <= i_event.new_address;
                        r_old_addr <= i_event.old_address;
                        r_bytes    <= i_event.byte_count;
                        r_state    <= S_REC;
                    end
                end
                S_REC: begin
                    r_rec <= do_rec;
                    r_rel <= 1'b0;
                    if (do_rec) begin
                        r_count <= r_count + CW'(1);
                        r_total <= r_total + att_pkg::TOTAL_W'(r_bytes);
                    end
                    r_state <= S_PEAK;
                end
                S_PEAK: begin
                    if (r_total > r_peak) begin
                        r_peak <= r_total;
                    end
                    r_rd_idx  <= '0;
                    r_cmp_vld <= 1'b0;
                    r_state   <= want_rel ? S_SCAN : S_DONE;
                end
                S_SCAN: begin
                    if (hit) begin
                        r_hit_idx  <= r_cmp_idx[AW-1:0];
                        r_hit_size <= ram_rdata[att_pkg::SIZE_W-1:0];
                        r_cmp_vld  <= 1'b0;
                        r_state    <= S_LAST_RD;
                    end else if (!r_cmp_vld && (r_rd_idx >= r_count)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cmp_idx <= r_rd_idx;
                        r_cmp_vld <= (r_rd_idx < r_count);
                        if (r_rd_idx < r_count) begin
                            r_rd_idx <= r_rd_idx + CW'(1);
                        end
                    end
                end
                S_LAST_RD: begin
                    r_state <= S_LAST_WR;
                end
                S_LAST_WR: begin
                    r_count <= count_m1;
                    r_total <= r_total - att_pkg::TOTAL_W'(r_hit_size);
                    r_rel   <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
